[hw/rtl/hws_pkg.sv]
// ============================================================================
// hws_pkg: shared types and constants for the heading to wheel speeds block
// Holds the request and result structs, the sequencer and turning mode
// enums, register indexes, reset values and the arctangent table.
// ============================================================================
package hws_pkg;

    typedef struct packed {
        logic signed [15:0] heading_x;
        logic signed [15:0] heading_y;
    } hws_in_t;

    typedef struct packed {
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
    } hws_out_t;

    typedef enum logic [1:0] {
        MODE_STRAIGHT = 2'd0,
        MODE_SOFT     = 2'd1,
        MODE_HARD     = 2'd2
    } hws_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_ITER,
        ST_MODE,
        ST_PROD,
        ST_DIVGO,
        ST_DIV,
        ST_DONE
    } hws_state_t;

    // Result of the divider.
    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [14:0] quot;
    } hws_div_res_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HARD     = 2'd0;
    localparam logic [1:0] CFG_SOFT     = 2'd1;
    localparam logic [1:0] CFG_STRAIGHT = 2'd2;
    localparam logic [1:0] CFG_MAXSPD   = 2'd3;

    localparam logic [15:0] HARD_RST     = 16'd16384;
    localparam logic [15:0] SOFT_RST     = 16'd12743;
    localparam logic [15:0] STRAIGHT_RST = 16'd1820;
    localparam logic [13:0] MAXSPD_RST   = 14'd2560;

    localparam int          CORDIC_STEPS = 15;
    localparam logic [3:0]  ITER_LAST    = 4'd15;
    localparam logic [3:0]  DIV_LAST     = 4'd14;
    localparam logic signed [17:0] QUARTER_TURN = 18'sd16384;

    // round(atan(2^-i) * 32768 / pi)
    function automatic logic signed [17:0] atan_lut(input logic [3:0] idx);
        logic signed [17:0] v;
        begin
            case (idx)
                4'd0:    v = 18'sd8192;
                4'd1:    v = 18'sd4836;
                4'd2:    v = 18'sd2555;
                4'd3:    v = 18'sd1297;
                4'd4:    v = 18'sd651;
                4'd5:    v = 18'sd326;
                4'd6:    v = 18'sd163;
                4'd7:    v = 18'sd81;
                4'd8:    v = 18'sd41;
                4'd9:    v = 18'sd20;
                4'd10:   v = 18'sd10;
                4'd11:   v = 18'sd5;
                4'd12:   v = 18'sd3;
                4'd13:   v = 18'sd1;
                4'd14:   v = 18'sd1;
                default: v = 18'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

[hw/rtl/heading_to_wheel_speeds_top.sv]
// ============================================================================
// heading_to_wheel_speeds_top: differential-drive steering from a heading
// Turns a heading vector into left and right wheel speeds, with a turning
// mode that moves between straight, soft and hard turn with hysteresis.
// ============================================================================
// One request is worked on at a time; s_ready rises again in the same
// cycle as its result is first held in the output register, and a new
// request cannot be taken before then. The work is done mostly in two
// loops: a 16-step loop in which one bit of the integer square root
// (length) is done per cycle and one CORDIC vectoring step (angle) in
// each of the first fifteen, and a 15-step restoring divider that forms
// the soft-turn speed offset. A single 18 by 18 multiplier is shared for
// the two squares and the speed product. The result waits in an output
// register, so a new request may be taken while the previous result is
// still pending; the final step of a request waits only if that register
// is still full.
// Configuration writes take effect at once and should be made while the
// block is idle. Angles are in binary units where 32768 stands for pi.
// ============================================================================
module heading_to_wheel_speeds_top import hws_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  hws_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output hws_out_t    m_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    hws_state_t state_reg, state_next;
    hws_mode_t  mode_reg, mode_next;

    // Configuration registers.
    logic [15:0] hard_reg, soft_reg, straight_reg;
    logic [13:0] maxspd_reg;

    // Request operands and CORDIC state.
    logic signed [15:0] hx_reg, hx_next, hy_reg, hy_next;
    logic               zero_reg, zero_next;
    logic signed [26:0] x_reg, x_next, y_reg, y_next;
    logic signed [17:0] z_reg, z_next;

    // Square root state: sq_reg holds the radicand as it is worn down.
    logic [31:0] sq_reg, sq_next, res_reg, res_next, bit_reg, bit_next;
    logic [3:0]  cnt_reg, cnt_next;

    logic signed [15:0] ang_reg, ang_next;
    logic [16:0]        abs_reg, abs_next;
    logic [13:0]        base_reg, base_next;
    logic [28:0]        num_reg, num_next;
    logic [13:0]        d_reg, d_next;

    hws_out_t out_reg, out_next;
    logic     m_valid_reg, m_valid_next;

    // Shared multiplier.
    logic signed [17:0] mul_a, mul_b;
    logic signed [35:0] mul_p;

    // Divider connection.
    logic         div_start;
    logic [30:0]  div_dividend;
    logic [16:0]  div_divisor;
    hws_div_res_t div_res;

    // Per-cycle working values.
    logic signed [26:0] x0, y0, xs, ys;
    logic [31:0]        trial;
    logic signed [15:0] a_w;
    logic [16:0]        abs_w;
    logic [15:0]        len_w;
    logic signed [15:0] s1, s2;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign mul_p = mul_a * mul_b;

    // Square of x, square of y, then the product base * |angle|.
    always_comb begin
        case (state_reg)
            ST_SQY: begin
                mul_a = 18'(hy_reg);
                mul_b = 18'(hy_reg);
            end
            ST_PROD: begin
                mul_a = $signed({4'b0, base_reg});
                mul_b = $signed({1'b0, abs_reg});
            end
            default: begin
                mul_a = 18'(hx_reg);
                mul_b = 18'(hx_reg);
            end
        endcase
    end

    // The divider forms round(base * |a| / hard) as
    // floor((2 * base * |a| + hard) / (2 * hard)).
    assign div_start    = (state_reg == ST_DIVGO);
    assign div_dividend = {1'b0, num_reg, 1'b0} + {15'b0, hard_reg};
    assign div_divisor  = {hard_reg, 1'b0};

    hws_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .res      (div_res)
    );

    // Inputs scaled by 256 into the CORDIC width.
    assign x0 = {{3{s_data.heading_x[15]}}, s_data.heading_x, 8'b0};
    assign y0 = {{3{s_data.heading_y[15]}}, s_data.heading_y, 8'b0};

    // Arithmetic shifts round towards minus infinity, as the steps require.
    assign xs    = x_reg >>> cnt_reg;
    assign ys    = y_reg >>> cnt_reg;
    assign trial = res_reg + bit_reg;

    // The angle wraps to 16 bits, so a half turn reads as -32768. A zero
    // vector has no direction and is given the angle zero.
    assign a_w   = zero_reg ? 16'sd0 : $signed(z_reg[15:0]);
    assign abs_w = a_w[15] ? (17'd0 - {1'b1, a_w}) : {1'b0, a_w};
    assign len_w = res_reg[15:0];

    // Speeds of the outer and inner wheel before the angle's sign assigns them.
    always_comb begin
        case (mode_reg)
            MODE_SOFT: begin
                s1 = $signed({2'b0, base_reg} - {2'b0, d_reg});
                s2 = $signed({2'b0, base_reg} + {2'b0, d_reg});
            end
            MODE_HARD: begin
                s1 = $signed(16'd0 - {2'b0, maxspd_reg});
                s2 = $signed({2'b0, maxspd_reg});
            end
            default: begin
                s1 = $signed({2'b0, base_reg});
                s2 = $signed({2'b0, base_reg});
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        hx_next      = hx_reg;
        hy_next      = hy_reg;
        zero_next    = zero_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        sq_next      = sq_reg;
        res_next     = res_reg;
        bit_next     = bit_reg;
        cnt_next     = cnt_reg;
        ang_next     = ang_reg;
        abs_next     = abs_reg;
        base_next    = base_reg;
        num_next     = num_reg;
        d_next       = d_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    hx_next   = s_data.heading_x;
                    hy_next   = s_data.heading_y;
                    zero_next = (s_data.heading_x == 16'sd0) && (s_data.heading_y == 16'sd0);
                    // A vector in the left half plane is first turned by a
                    // quarter turn so that the iterations converge.
                    if (s_data.heading_x[15]) begin
                        if (!s_data.heading_y[15]) begin
                            x_next = y0;
                            y_next = -x0;
                            z_next = QUARTER_TURN;
                        end else begin
                            x_next = -y0;
                            y_next = x0;
                            z_next = -QUARTER_TURN;
                        end
                    end else begin
                        x_next = x0;
                        y_next = y0;
                        z_next = 18'sd0;
                    end
                    state_next = ST_SQX;
                end
            end
            ST_SQX: begin
                sq_next    = mul_p[31:0];
                state_next = ST_SQY;
            end
            ST_SQY: begin
                sq_next    = sq_reg + mul_p[31:0];
                res_next   = 32'd0;
                bit_next   = 32'h4000_0000;
                cnt_next   = 4'd0;
                state_next = ST_ITER;
            end
            ST_ITER: begin
                // One bit of the square root each cycle.
                if (sq_reg >= trial) begin
                    sq_next  = sq_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                // One CORDIC vectoring step in each of the first fifteen.
                if (cnt_reg != ITER_LAST) begin
                    if (y_reg > 27'sd0) begin
                        x_next = x_reg + ys;
                        y_next = y_reg - xs;
                        z_next = z_reg + atan_lut(cnt_reg);
                    end else begin
                        x_next = x_reg - ys;
                        y_next = y_reg + xs;
                        z_next = z_reg - atan_lut(cnt_reg);
                    end
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == ITER_LAST) begin
                    state_next = ST_MODE;
                end
            end
            ST_MODE: begin
                ang_next  = a_w;
                abs_next  = abs_w;
                base_next = (len_w < {2'b0, maxspd_reg}) ? len_w[13:0] : maxspd_reg;
                // Soft turn can only be entered from straight; leaving it needs the angle
                // to fall to the straight threshold or to rise above the hard threshold.
                if (abs_w <= {1'b0, straight_reg}) begin
                    mode_next = MODE_STRAIGHT;
                end else if (abs_w > {1'b0, hard_reg}) begin
                    mode_next = MODE_HARD;
                end else if (mode_reg == MODE_STRAIGHT && abs_w > {1'b0, soft_reg}) begin
                    mode_next = MODE_SOFT;
                end
                state_next = ST_PROD;
            end
            ST_PROD: begin
                num_next   = mul_p[28:0];
                state_next = ST_DIVGO;
            end
            ST_DIVGO: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_res.done) begin
                    // The offset never exceeds the base speed.
                    if (div_res.ovf || div_res.quot > {1'b0, base_reg}) begin
                        d_next = base_reg;
                    end else begin
                        d_next = div_res.quot[13:0];
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    if (ang_reg > 16'sd0) begin
                        out_next.left_speed  = s1;
                        out_next.right_speed = s2;
                    end else begin
                        out_next.left_speed  = s2;
                        out_next.right_speed = s1;
                    end
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= MODE_STRAIGHT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            m_valid_reg <= m_valid_next;
        end
        hx_reg   <= hx_next;
        hy_reg   <= hy_next;
        zero_reg <= zero_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        sq_reg   <= sq_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        cnt_reg  <= cnt_next;
        ang_reg  <= ang_next;
        abs_reg  <= abs_next;
        base_reg <= base_next;
        num_reg  <= num_next;
        d_reg    <= d_next;
        out_reg  <= out_next;
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hard_reg     <= HARD_RST;
            soft_reg     <= SOFT_RST;
            straight_reg <= STRAIGHT_RST;
            maxspd_reg   <= MAXSPD_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_HARD:     hard_reg     <= cfg_wdata;
                CFG_SOFT:     soft_reg     <= cfg_wdata;
                CFG_STRAIGHT: straight_reg <= cfg_wdata;
                CFG_MAXSPD:   maxspd_reg   <= cfg_wdata[13:0];
                default: begin
                end
            endcase
        end
    end

endmodule

[hw/rtl/hws_div.sv]
// ============================================================================
// hws_div: iterative restoring divider
// Produces a 15-bit quotient one bit per cycle, with a flag for quotients
// that do not fit in 15 bits.
// ============================================================================
module hws_div import hws_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [30:0]   dividend,
    input  logic [16:0]   divisor,
    output hws_div_res_t  res
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [30:0] rem_reg, rem_next;
    logic [30:0] ds_reg, ds_next;
    logic [14:0] quot_reg, quot_next;
    logic        ovf_reg, ovf_next;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        ds_next   = ds_reg;
        quot_next = quot_reg;
        ovf_next  = ovf_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 4'd0;
            rem_next  = dividend;
            ds_next   = {divisor, 14'b0};
            quot_next = 15'd0;
            ovf_next  = ({1'b0, dividend} >= {divisor, 15'b0});
        end else if (busy_reg) begin
            if (rem_reg >= ds_reg) begin
                rem_next  = rem_reg - ds_reg;
                quot_next = {quot_reg[13:0], 1'b1};
            end else begin
                quot_next = {quot_reg[13:0], 1'b0};
            end
            ds_next  = ds_reg >> 1;
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == DIV_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        ds_reg   <= ds_next;
        quot_reg <= quot_next;
        ovf_reg  <= ovf_next;
    end

    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.quot = quot_reg;

endmodule

[hw/rtl/hws_chk.sv]
// ============================================================================
// hws_chk: port-level checks for the heading to wheel speeds block
// Watches the request and result channels over time; bound to the top level.
// ============================================================================
module hws_chk import hws_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input hws_out_t    m_data
);

    // A pending result is held until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // Only one request is worked on at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while another is in progress");

    // Reset leaves the block empty and ready.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

    // A result cannot appear straight after its request.
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result appeared too early");

endmodule

bind heading_to_wheel_speeds_top hws_chk u_hws_chk (.*);
